### rtl/core/cso_pkg.sv
package cso_pkg;

    // default sprite size
    localparam int unsigned SPRITE_W_DEF = 32;
    localparam int unsigned SPRITE_H_DEF = 32;

    // field widths
    localparam int unsigned COORD_W = 12;
    localparam int unsigned HOT_W   = 5;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned COLOR_W = 3 * CHAN_W;
    // sprite entry: opacity bit above the color
    localparam int unsigned ENTRY_W = COLOR_W + 1;

    // stream data widths, padded to whole bytes
    localparam int unsigned S_DATA_BITS = 2 * COORD_W + COLOR_W + 1;
    localparam int unsigned S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W   = COLOR_W;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = COORD_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CURSOR_X = 2'd0,
        REG_CURSOR_Y = 2'd1,
        REG_HOT_X    = 2'd2,
        REG_HOT_Y    = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        REQ_COMPOSE = 1'b0,
        REQ_LOAD    = 1'b1
    } req_type_t;

endpackage

### rtl/core/cso_axis_offset.sv
module cso_axis_offset
    import cso_pkg::*;
#(
    parameter int unsigned SIZE  = SPRITE_W_DEF,
    parameter int unsigned OFF_W = $clog2(SIZE)
) (
    input  logic [COORD_W-1:0] pos,
    input  logic [HOT_W-1:0]   hot,
    input  logic [COORD_W-1:0] cur,
    output logic               in_sprite,
    output logic [OFF_W-1:0]   off
);

    logic [COORD_W:0]   shifted;
    logic [COORD_W+1:0] diff;

    // pos + hot - cur without wrap; top bit of diff flags a negative offset
    always_comb begin
        shifted   = {1'b0, pos} + (COORD_W+1)'(hot);
        diff      = {1'b0, shifted} - (COORD_W+2)'(cur);
        in_sprite = !diff[COORD_W+1] && (diff[COORD_W:0] < (COORD_W+1)'(SIZE));
        off       = diff[OFF_W-1:0];
    end

endmodule

### rtl/core/cso_sprite_mem.sv
module cso_sprite_mem
    import cso_pkg::*;
#(
    parameter int unsigned DEPTH = SPRITE_W_DEF * SPRITE_H_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [ENTRY_W-1:0] rd_data,
    output logic               clear_busy
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic               clr_busy_reg, clr_busy_next;

    // clearing pass after reset, one entry per cycle
    always_comb begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end else begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clr_busy_reg;

endmodule

### rtl/core/cursor_sprite_overlay.sv
// hardware cursor overlay on a scanout pixel stream
// s_ takes one item per cycle while s_tready is high; tuser: compose (0), sprite load (1).
// a load item writes one sprite entry (color and opacity bit) at row * SPRITE_W + column
// and gives no result; a load outside the sprite is dropped.
// a compose item gives exactly one m_ item: the sprite color with tuser (cursor hit) set
// when the pixel falls inside the sprite placed at cursor - hotspot and the entry is
// opaque, else the background color with tuser clear.
// a result reaches m_ through two registers: the sprite read, then the output register.
// throughput: one item per cycle while s_tready is high, set by the single sprite ram port
// pair (one write for loads, one registered read for composes).
// a load followed by a compose in the very next cycle sees the new entry.
// reset: cursor and hotspot registers go to 0, then a clearing pass zeroes all
// SPRITE_W * SPRITE_H sprite ram entries, during which s_tready stays low;
// configuration writes are taken at any time.
// stall: with m_tready low the output register holds its item and the middle stage
// still takes one more compose item before s_tready drops; loads do not fill it.
// config: cfg_wr_en writes cfg_wdata into register cfg_index (cursor_x, cursor_y,
// hot_x, hot_y); write only while no item is in flight.
module cursor_sprite_overlay
    import cso_pkg::*;
#(
    parameter int unsigned SPRITE_W = SPRITE_W_DEF,
    parameter int unsigned SPRITE_H = SPRITE_H_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    // input item channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // coord_x[11:0], coord_y[23:12], in_red[31:24], in_green[39:32], in_blue[47:40],
    // load_mask[48], zero pad above
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // req_type[0]
    input  logic                   s_tuser,

    // result item channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [M_TDATA_W-1:0]   m_tdata,
    // cursor_hit[0]
    output logic                   m_tuser
);

    localparam int unsigned DEPTH = SPRITE_W * SPRITE_H;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned XW    = $clog2(SPRITE_W);
    localparam int unsigned YW    = $clog2(SPRITE_H);

    // configuration registers
    logic [COORD_W-1:0] cursor_x_reg, cursor_y_reg;
    logic [HOT_W-1:0]   hot_x_reg, hot_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            hot_x_reg    <= '0;
            hot_y_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CURSOR_X: cursor_x_reg <= cfg_wdata;
                REG_CURSOR_Y: cursor_y_reg <= cfg_wdata;
                REG_HOT_X:    hot_x_reg    <= cfg_wdata[HOT_W-1:0];
                REG_HOT_Y:    hot_y_reg    <= cfg_wdata[HOT_W-1:0];
                default:      ;
            endcase
        end
    end

    // input item fields
    logic [COORD_W-1:0] in_coord_x, in_coord_y;
    logic [COLOR_W-1:0] in_color;     // red in the top byte, as stored in the ram
    logic               in_mask;
    logic               in_is_load;

    assign in_coord_x = s_tdata[COORD_W-1:0];
    assign in_coord_y = s_tdata[2*COORD_W-1:COORD_W];
    assign in_color   = {s_tdata[2*COORD_W +: CHAN_W],
                         s_tdata[2*COORD_W+CHAN_W +: CHAN_W],
                         s_tdata[2*COORD_W+2*CHAN_W +: CHAN_W]};
    assign in_mask    = s_tdata[2*COORD_W+COLOR_W];
    assign in_is_load = (req_type_t'(s_tuser) == REQ_LOAD);

    // pipeline handshake
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg, m_valid_next;
    logic out_free, s1_free, clear_busy, accept;

    assign out_free = !m_valid_reg || m_tready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign s_tready = s1_free && !clear_busy;
    assign accept   = s_tvalid && s_tready;

    // sprite load address
    logic          load_in_range, wr_en;
    logic [AW-1:0] wr_addr;

    assign load_in_range = (in_coord_x < COORD_W'(SPRITE_W)) &&
                           (in_coord_y < COORD_W'(SPRITE_H));
    assign wr_en   = accept && in_is_load && load_in_range;
    assign wr_addr = AW'(in_coord_y[YW-1:0]) * AW'(SPRITE_W) + AW'(in_coord_x[XW-1:0]);

    // compose: offset from the cursor origin on each axis
    logic          inside_x, inside_y;
    logic [XW-1:0] off_x;
    logic [YW-1:0] off_y;
    logic [AW-1:0] rd_addr;

    cso_axis_offset #(
        .SIZE  (SPRITE_W),
        .OFF_W (XW)
    ) u_off_x (
        .pos       (in_coord_x),
        .hot       (hot_x_reg),
        .cur       (cursor_x_reg),
        .in_sprite (inside_x),
        .off       (off_x)
    );

    cso_axis_offset #(
        .SIZE  (SPRITE_H),
        .OFF_W (YW)
    ) u_off_y (
        .pos       (in_coord_y),
        .hot       (hot_y_reg),
        .cur       (cursor_y_reg),
        .in_sprite (inside_y),
        .off       (off_y)
    );

    assign rd_addr = AW'(off_y) * AW'(SPRITE_W) + AW'(off_x);

    // sprite ram, read registered alongside stage 1
    logic [ENTRY_W-1:0] rd_entry;

    cso_sprite_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    ({in_mask, in_color}),
        .rd_en      (s1_free),
        .rd_addr    (rd_addr),
        .rd_data    (rd_entry),
        .clear_busy (clear_busy)
    );

    // stage 1: background color and window test, waiting on the ram read
    logic [COLOR_W-1:0] s1_bg_reg;
    logic               s1_inside_reg;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s1_free) begin
            s1_valid_next = accept && !in_is_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_free) begin
            s1_bg_reg     <= in_color;
            s1_inside_reg <= inside_x && inside_y;
        end
    end

    // stage 2: output register
    logic               hit;
    logic [COLOR_W-1:0] out_color;
    logic [COLOR_W-1:0] m_color_reg;
    logic               m_hit_reg;

    assign hit       = s1_inside_reg && rd_entry[COLOR_W];
    assign out_color = hit ? rd_entry[COLOR_W-1:0] : s1_bg_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_color_reg <= out_color;
            m_hit_reg   <= hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    // stored color has red on top; the stream puts red in the low byte
    assign m_tdata  = {m_color_reg[CHAN_W-1:0],
                       m_color_reg[2*CHAN_W-1:CHAN_W],
                       m_color_reg[3*CHAN_W-1:2*CHAN_W]};
    assign m_tuser  = m_hit_reg;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cso_pkg::*;

    localparam int SPRITE_W       = SPRITE_W_DEF;
    localparam int SPRITE_H       = SPRITE_H_DEF;
    localparam int SPRITE_ENTRIES = SPRITE_W * SPRITE_H;
    localparam int COORD_MAX      = (1 << COORD_W) - 1;
    localparam int HOT_MAX        = (1 << HOT_W) - 1;
    localparam int HOLD_CYCLES    = 300;

    // receiver behavior on m_tready
    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN
    } ready_mode_t;

    // one composited pixel as it leaves the block
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              hit;
    } pixel_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    cfg_reg_t               cfg_index = REG_CURSOR_X;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // coord_x[11:0], coord_y[23:12], in_red[31:24], in_green[39:32], in_blue[47:40],
    // load_mask[48], zero pad above
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    // req_type[0]
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    logic [M_TDATA_W-1:0]   m_tdata;
    // cursor_hit[0]
    logic                   m_tuser;

    // our own copy of the cursor registers and the sprite store
    logic [COORD_W-1:0]     pos_x   = '0;
    logic [COORD_W-1:0]     pos_y   = '0;
    logic [HOT_W-1:0]       hot_col = '0;
    logic [HOT_W-1:0]       hot_row = '0;
    logic [COLOR_W-1:0]     sprite_rgb    [SPRITE_ENTRIES];
    bit                     sprite_opaque [SPRITE_ENTRIES];

    // composited pixels still owed by the block, oldest first
    pixel_t                 expected_pixels [$];

    // sender and receiver knobs
    bit                     gaps_on       = 1'b1;
    int                     burst_left    = 0;
    ready_mode_t            ready_mode    = READY_ALWAYS;
    logic [15:0]            ready_pattern = 16'hffff;
    logic [3:0]             pattern_pos   = '0;
    int                     hold_left     = 0;

    // last sprite entry loaded, so compose items can aim at it
    int                     last_col = 0;
    int                     last_row = 0;

    int                     mismatches    = 0;
    int                     composes_seen = 0;
    int                     loads_seen    = 0;
    int                     hits_seen     = 0;
    int                     reg_writes    = 0;

    cursor_sprite_overlay #(
        .SPRITE_W (SPRITE_W),
        .SPRITE_H (SPRITE_H)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
        end
    endtask

    // a load updates the sprite copy; a compose pushes the pixel it must produce
    function automatic void predict_overlay(input logic [S_TDATA_W-1:0] data,
                                            input logic req);
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [CHAN_W-1:0]  r;
        logic [CHAN_W-1:0]  g;
        logic [CHAN_W-1:0]  b;
        logic               opaque;
        int                 dx;
        int                 dy;
        int                 addr;
        pixel_t             pix;
        px     = data[11:0];
        py     = data[23:12];
        r      = data[31:24];
        g      = data[39:32];
        b      = data[47:40];
        opaque = data[48];
        if (req_type_t'(req) == REQ_LOAD) begin
            // entries outside the sprite are dropped
            if (px < SPRITE_W && py < SPRITE_H) begin
                addr = int'(py) * SPRITE_W + int'(px);
                sprite_rgb[addr]    = {r, g, b};
                sprite_opaque[addr] = opaque;
            end
            return;
        end
        // offset from the cursor origin, no wrap: negative means left of or above it
        dx  = int'(px) + int'(hot_col) - int'(pos_x);
        dy  = int'(py) + int'(hot_row) - int'(pos_y);
        pix = '{red: r, green: g, blue: b, hit: 1'b0};
        if (dx >= 0 && dx < SPRITE_W && dy >= 0 && dy < SPRITE_H) begin
            addr = dy * SPRITE_W + dx;
            if (sprite_opaque[addr]) begin
                pix = {sprite_rgb[addr], 1'b1};
            end
        end
        expected_pixels.push_back(pix);
    endfunction

    // results are checked before the same edge's input item is predicted
    always @(posedge aclk) begin : scoreboard
        pixel_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result with nothing expected", {m_tuser, m_tdata}, '0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_tdata[7:0] !== want.red) begin
                        report_mismatch("out_red", m_tdata[7:0], want.red);
                    end
                    if (m_tdata[15:8] !== want.green) begin
                        report_mismatch("out_green", m_tdata[15:8], want.green);
                    end
                    if (m_tdata[23:16] !== want.blue) begin
                        report_mismatch("out_blue", m_tdata[23:16], want.blue);
                    end
                    if (m_tuser !== want.hit) begin
                        report_mismatch("cursor_hit", m_tuser, want.hit);
                    end
                    if (want.hit) begin
                        hits_seen++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_overlay(s_tdata, s_tuser);
                if (req_type_t'(s_tuser) == REQ_LOAD) begin
                    loads_seen++;
                end else begin
                    composes_seen++;
                end
            end
        end
    end

    // receiver: a long hold-off when asked, otherwise the current stall mode
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            case (ready_mode)
                READY_ALWAYS: begin
                    m_tready <= 1'b1;
                end
                READY_RANDOM: begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    m_tready    <= ready_pattern[pattern_pos];
                    pattern_pos <= pattern_pos + 1'b1;
                end
            endcase
        end
    end

    // offer one item and hold it until the block takes it; bursts with random gaps
    task automatic send_item(input req_type_t req, input int px, input int py,
                             input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b, input logic opaque);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 4);
            if ($urandom_range(0, 7) == 0) begin
                gap = $urandom_range(5, 15);
            end
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= S_TDATA_W'({opaque, b, g, r, COORD_W'(py), COORD_W'(px)});
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering and let every owed pixel come out, plus room for a trailing load
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // write all four cursor registers back to back; block must be idle
    task automatic place_cursor(input int x, input int y, input int hx, input int hy);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_CURSOR_X;
        cfg_wdata <= CFG_DATA_W'(x);
        @(posedge aclk);
        cfg_index <= REG_CURSOR_Y;
        cfg_wdata <= CFG_DATA_W'(y);
        @(posedge aclk);
        cfg_index <= REG_HOT_X;
        cfg_wdata <= CFG_DATA_W'(HOT_W'(hx));
        @(posedge aclk);
        cfg_index <= REG_HOT_Y;
        cfg_wdata <= CFG_DATA_W'(HOT_W'(hy));
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        pos_x      = COORD_W'(x);
        pos_y      = COORD_W'(y);
        hot_col    = HOT_W'(hx);
        hot_row    = HOT_W'(hy);
        reg_writes += 4;
    endtask

    // mostly pixels aimed at the sprite, some sprite loads and some noise
    task automatic send_random_item();
        int                pick;
        int                ax;
        int                ay;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        r    = CHAN_W'($urandom());
        g    = CHAN_W'($urandom());
        b    = CHAN_W'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            last_col = $urandom_range(0, SPRITE_W - 1);
            last_row = $urandom_range(0, SPRITE_H - 1);
            send_item(REQ_LOAD, last_col, last_row, r, g, b, $urandom_range(0, 9) < 7);
        end else if (pick < 30) begin
            // load beyond the sprite bounds, must be dropped
            ax = $urandom_range(0, COORD_MAX);
            ay = $urandom_range(SPRITE_H, COORD_MAX);
            if ($urandom_range(0, 1) != 0) begin
                ax = $urandom_range(SPRITE_W, COORD_MAX);
                ay = $urandom_range(0, COORD_MAX);
            end
            send_item(REQ_LOAD, ax, ay, r, g, b, 1'($urandom()));
        end else if (pick < 85) begin
            // pixel on the last loaded entry, or anywhere around the sprite window
            if (pick < 55) begin
                ax = last_col;
                ay = last_row;
            end else begin
                ax = int'($urandom_range(0, SPRITE_W + 5)) - 3;
                ay = int'($urandom_range(0, SPRITE_H + 5)) - 3;
            end
            ax = ax + int'(pos_x) - int'(hot_col);
            ay = ay + int'(pos_y) - int'(hot_row);
            if (ax < 0 || ax > COORD_MAX) begin
                ax = $urandom_range(0, COORD_MAX);
            end
            if (ay < 0 || ay > COORD_MAX) begin
                ay = $urandom_range(0, COORD_MAX);
            end
            send_item(REQ_COMPOSE, ax, ay, r, g, b, 1'($urandom()));
        end else begin
            send_item(REQ_COMPOSE, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      r, g, b, 1'($urandom()));
        end
    endtask

    // mask store is clear after reset: every pixel is background, no hit
    task automatic test_transparent_after_reset();
        send_item(REQ_COMPOSE, 0, 0, 8'hff, 8'hff, 8'hff, 1'b0);
        send_item(REQ_COMPOSE, SPRITE_W - 1, SPRITE_H - 1, 8'h00, 8'h00, 8'h00, 1'b1);
        send_item(REQ_COMPOSE, COORD_MAX, COORD_MAX, 8'h5a, 8'ha5, 8'h3c, 1'b0);
        send_item(REQ_COMPOSE, 5, 7, 8'h01, 8'h80, 8'hfe, 1'b1);
        wait_all_results();
    endtask

    // corner entries, a transparent entry and loads outside the sprite
    task automatic test_sprite_corners();
        send_item(REQ_LOAD, 0, 0, 8'hff, 8'h00, 8'h00, 1'b1);
        send_item(REQ_LOAD, SPRITE_W - 1, 0, 8'h00, 8'hff, 8'h00, 1'b1);
        send_item(REQ_LOAD, 0, SPRITE_H - 1, 8'h00, 8'h00, 8'hff, 1'b1);
        send_item(REQ_LOAD, SPRITE_W - 1, SPRITE_H - 1, 8'hff, 8'hff, 8'hff, 1'b1);
        send_item(REQ_LOAD, 1, 1, 8'h12, 8'h34, 8'h56, 1'b0);
        // the first two would land on entry 0 if the address wrapped, the third on the last
        send_item(REQ_LOAD, SPRITE_W, 0, 8'h80, 8'h80, 8'h80, 1'b1);
        send_item(REQ_LOAD, 0, SPRITE_H, 8'h81, 8'h81, 8'h81, 1'b1);
        send_item(REQ_LOAD, COORD_MAX, COORD_MAX, 8'h82, 8'h82, 8'h82, 1'b1);
        // cursor and hotspot still at zero: screen pixel equals sprite entry
        send_item(REQ_COMPOSE, 0, 0, 8'h00, 8'hff, 8'hff, 1'b0);
        send_item(REQ_COMPOSE, SPRITE_W - 1, 0, 8'hff, 8'h00, 8'hff, 1'b0);
        send_item(REQ_COMPOSE, 0, SPRITE_H - 1, 8'hff, 8'hff, 8'h00, 1'b0);
        send_item(REQ_COMPOSE, SPRITE_W - 1, SPRITE_H - 1, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(REQ_COMPOSE, 1, 1, 8'h77, 8'h66, 8'h55, 1'b1);
        send_item(REQ_COMPOSE, SPRITE_W, 0, 8'h44, 8'h33, 8'h22, 1'b0);
        send_item(REQ_COMPOSE, 0, SPRITE_H, 8'h11, 8'h22, 8'h33, 1'b1);
        wait_all_results();
    endtask

    // sprite hanging off the bottom-right and the top-left of the screen
    task automatic test_screen_edges();
        place_cursor(COORD_MAX - 1, COORD_MAX, HOT_MAX, HOT_MAX);
        send_item(REQ_COMPOSE, COORD_MAX - 1, COORD_MAX, 8'h10, 8'h20, 8'h30, 1'b0);
        send_item(REQ_COMPOSE, COORD_MAX, COORD_MAX, 8'h40, 8'h50, 8'h60, 1'b0);
        wait_all_results();
        // origin at (-7, -7); entry (6, 7) sits off screen and must stay hidden
        send_item(REQ_LOAD, 6, 7, 8'hc0, 8'hde, 8'had, 1'b1);
        wait_all_results();
        place_cursor(3, 2, 10, 9);
        send_item(REQ_COMPOSE, COORD_MAX, 0, 8'h0f, 8'hf0, 8'h0f, 1'b0);
        send_item(REQ_COMPOSE, 24, 25, 8'h99, 8'h88, 8'h77, 1'b1);
        send_item(REQ_COMPOSE, 25, 24, 8'h66, 8'h55, 8'h44, 1'b0);
        wait_all_results();
    endtask

    // receiver holds off while the sender keeps offering, so the block backs up
    task automatic test_output_holdoff();
        gaps_on    = 1'b0;
        ready_mode <= READY_ALWAYS;
        hold_left  <= HOLD_CYCLES;
        repeat (40) send_random_item();
        wait_all_results();
        gaps_on = 1'b1;
    endtask

    // six cursor placements, extremes first, cycling through the three stall modes
    task automatic test_random_overlay();
        for (int phase = 0; phase < 6; phase++) begin
            wait_all_results();
            case (phase)
                0: place_cursor(0, 0, 0, 0);
                1: place_cursor(COORD_MAX, COORD_MAX, HOT_MAX, HOT_MAX);
                2: place_cursor(0, COORD_MAX, HOT_MAX, 0);
                default: place_cursor($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                      $urandom_range(0, HOT_MAX), $urandom_range(0, HOT_MAX));
            endcase
            ready_mode    <= ready_mode_t'(phase % 3);
            ready_pattern <= 16'($urandom()) | 16'h0101;
            // one phase runs flat out on both sides
            gaps_on = (phase != 3);
            repeat (55) send_random_item();
        end
        gaps_on = 1'b1;
    endtask

    initial begin : run_tests
        int drain_wait;
        drain_wait = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        // the sender simply waits out the sprite clearing pass on s_tready
        test_transparent_after_reset();
        test_sprite_corners();
        test_screen_edges();
        test_output_holdoff();
        test_random_overlay();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0 && drain_wait < 5000) begin
            @(posedge aclk);
            drain_wait++;
        end
        repeat (8) @(posedge aclk);
        if (expected_pixels.size() != 0) begin
            report_mismatch("pixels never returned", expected_pixels.size(), 0);
        end
        $display("covered %0d compose items (%0d with the cursor on top) and %0d sprite loads",
                 composes_seen, hits_seen, loads_seen);
        $display("over %0d register writes, random and patterned stalls and a %0d-cycle hold-off",
                 reg_writes, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
rtl/core/cso_pkg.sv
rtl/core/cso_axis_offset.sv
rtl/core/cso_sprite_mem.sv
rtl/core/cursor_sprite_overlay.sv
tb/tb_top.sv
